>>> hdl/tos_pkg.sv
// ----------------------------------------------------------------------------
// tos_pkg
// Shared widths, types and stage control for the triangle overlap core.
// ----------------------------------------------------------------------------
`default_nettype none

package tos_pkg;

  localparam int unsigned CoordWidth = 16;
  localparam int unsigned NormWidth  = CoordWidth + 1;
  localparam int unsigned ProdWidth  = CoordWidth + NormWidth;
  localparam int unsigned DotWidth   = ProdWidth + 1;
  localparam int unsigned NumVert    = 6;
  localparam int unsigned NumAxis    = 6;
  localparam int unsigned TriVert    = 3;

  typedef logic signed [CoordWidth-1:0] coord_t;
  typedef logic signed [NormWidth-1:0]  norm_t;
  typedef logic signed [ProdWidth-1:0]  prod_t;
  typedef logic signed [DotWidth-1:0]   dot_t;

  typedef coord_t vert_arr_t [NumVert];

  typedef struct packed {
    logic ld3;
    logic ld4;
    logic ld5;
  } stage_ld_t;

endpackage

`default_nettype wire

>>> hdl/tos_if.sv
// ----------------------------------------------------------------------------
// tos_if
// Valid/ready channels: triangle pair beat in, overlap flag beat out.
// ----------------------------------------------------------------------------
`default_nettype none

interface tos_in_if;
  logic           valid;
  logic           ready;
  tos_pkg::coord_t a0_x;
  tos_pkg::coord_t a0_y;
  tos_pkg::coord_t a1_x;
  tos_pkg::coord_t a1_y;
  tos_pkg::coord_t a2_x;
  tos_pkg::coord_t a2_y;
  tos_pkg::coord_t b0_x;
  tos_pkg::coord_t b0_y;
  tos_pkg::coord_t b1_x;
  tos_pkg::coord_t b1_y;
  tos_pkg::coord_t b2_x;
  tos_pkg::coord_t b2_y;

  modport source (
    output valid, a0_x, a0_y, a1_x, a1_y, a2_x, a2_y,
    output b0_x, b0_y, b1_x, b1_y, b2_x, b2_y,
    input  ready
  );
  modport sink (
    input  valid, a0_x, a0_y, a1_x, a1_y, a2_x, a2_y,
    input  b0_x, b0_y, b1_x, b1_y, b2_x, b2_y,
    output ready
  );
endinterface

interface tos_out_if;
  logic valid;
  logic ready;
  logic overlap;

  modport source (output valid, overlap, input ready);
  modport sink (input valid, overlap, output ready);
endinterface

`default_nettype wire

>>> hdl/tos_axis.sv
// ----------------------------------------------------------------------------
// tos_axis
// One candidate axis: projects all six vertices, forms both triangles'
// intervals and flags a gap between them.
// ----------------------------------------------------------------------------
`default_nettype none

module tos_axis (
  input  wire                  clk_i,
  input  tos_pkg::stage_ld_t   ld_i,
  input  tos_pkg::vert_arr_t   x_i,
  input  tos_pkg::vert_arr_t   y_i,
  input  tos_pkg::norm_t       nx_i,
  input  tos_pkg::norm_t       ny_i,
  output logic                 sep_o
);

  tos_pkg::prod_t px_q [tos_pkg::NumVert];
  tos_pkg::prod_t py_q [tos_pkg::NumVert];
  tos_pkg::dot_t  d_q  [tos_pkg::NumVert];
  tos_pkg::dot_t  lo_a_q, hi_a_q, lo_b_q, hi_b_q;

  function automatic tos_pkg::dot_t min3(tos_pkg::dot_t a, tos_pkg::dot_t b,
                                         tos_pkg::dot_t c);
    tos_pkg::dot_t m;
    m = (b < a) ? b : a;
    m = (c < m) ? c : m;
    return m;
  endfunction

  function automatic tos_pkg::dot_t max3(tos_pkg::dot_t a, tos_pkg::dot_t b,
                                         tos_pkg::dot_t c);
    tos_pkg::dot_t m;
    m = (b > a) ? b : a;
    m = (c > m) ? c : m;
    return m;
  endfunction

  // products
  always_ff @(posedge clk_i) begin
    if (ld_i.ld3) begin
      for (int i = 0; i < tos_pkg::NumVert; i++) begin
        px_q[i] <= tos_pkg::prod_t'(x_i[i]) * tos_pkg::prod_t'(nx_i);
        py_q[i] <= tos_pkg::prod_t'(y_i[i]) * tos_pkg::prod_t'(ny_i);
      end
    end
  end

  // dot products
  always_ff @(posedge clk_i) begin
    if (ld_i.ld4) begin
      for (int i = 0; i < tos_pkg::NumVert; i++) begin
        d_q[i] <= tos_pkg::dot_t'(px_q[i]) + tos_pkg::dot_t'(py_q[i]);
      end
    end
  end

  // intervals
  always_ff @(posedge clk_i) begin
    if (ld_i.ld5) begin
      lo_a_q <= min3(d_q[0], d_q[1], d_q[2]);
      hi_a_q <= max3(d_q[0], d_q[1], d_q[2]);
      lo_b_q <= min3(d_q[3], d_q[4], d_q[5]);
      hi_b_q <= max3(d_q[3], d_q[4], d_q[5]);
    end
  end

  // touching intervals still overlap
  assign sep_o = (hi_b_q < lo_a_q) || (hi_a_q < lo_b_q);

endmodule

`default_nettype wire

>>> hdl/triangle_overlap_sat_core.sv
// ----------------------------------------------------------------------------
// triangle_overlap_sat_core
// 2D separating-axis overlap test of two triangles, one pair per beat.
// ----------------------------------------------------------------------------
// A beat passes the input, normal, product, dot, interval and output registers.
// Throughput: one triangle pair per cycle while the output is not stalled; all six
//   axes are projected in parallel by 72 multipliers, one pipeline stage per step.
// Stalls propagate stage by stage, so empty stages keep accepting beats.
// Reset clears the stage valid bits and the output valid; data is not reset.
`default_nettype none

module triangle_overlap_sat_core (
  input  wire        clk_i,
  input  wire        rst_ni,
  tos_in_if.sink     in_i,
  tos_out_if.source  out_o
);

  logic v1_q, v2_q, v3_q, v4_q, v5_q, ov_q;
  logic ld1, ld2, ld3, ld4, ld5, ld_out;

  tos_pkg::vert_arr_t x1_q, y1_q, x2_q, y2_q;
  tos_pkg::norm_t     nx_d [tos_pkg::NumAxis];
  tos_pkg::norm_t     ny_d [tos_pkg::NumAxis];
  tos_pkg::norm_t     nx_q [tos_pkg::NumAxis];
  tos_pkg::norm_t     ny_q [tos_pkg::NumAxis];
  tos_pkg::stage_ld_t stage_ld;
  logic [tos_pkg::NumAxis-1:0] sep;
  logic overlap_q, overlap_d;

  // stage loads
  assign ld_out = !ov_q || out_o.ready;
  assign ld5    = !v5_q || ld_out;
  assign ld4    = !v4_q || ld5;
  assign ld3    = !v3_q || ld4;
  assign ld2    = !v2_q || ld3;
  assign ld1    = !v1_q || ld2;

  assign in_i.ready = ld1;
  assign stage_ld   = '{ld3: ld3, ld4: ld4, ld5: ld5};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      if (ld1)    v1_q <= in_i.valid;
      if (ld2)    v2_q <= v1_q;
      if (ld3)    v3_q <= v2_q;
      if (ld4)    v4_q <= v3_q;
      if (ld5)    v5_q <= v4_q;
      if (ld_out) ov_q <= v5_q;
    end
  end

  // input register
  always_ff @(posedge clk_i) begin
    if (ld1) begin
      x1_q[0] <= in_i.a0_x;
      y1_q[0] <= in_i.a0_y;
      x1_q[1] <= in_i.a1_x;
      y1_q[1] <= in_i.a1_y;
      x1_q[2] <= in_i.a2_x;
      y1_q[2] <= in_i.a2_y;
      x1_q[3] <= in_i.b0_x;
      y1_q[3] <= in_i.b0_y;
      x1_q[4] <= in_i.b1_x;
      y1_q[4] <= in_i.b1_y;
      x1_q[5] <= in_i.b2_x;
      y1_q[5] <= in_i.b2_y;
    end
  end

  // edge normals: axis a uses edge k -> (k+1) mod 3, k = a % 3, of triangle a / 3
  for (genvar a = 0; a < tos_pkg::NumAxis; a++) begin : g_norm
    localparam int P = (a / tos_pkg::TriVert) * tos_pkg::TriVert + (a % tos_pkg::TriVert);
    localparam int Q = (a / tos_pkg::TriVert) * tos_pkg::TriVert
                       + ((a % tos_pkg::TriVert) + 1) % tos_pkg::TriVert;
    assign nx_d[a] = tos_pkg::norm_t'(y1_q[Q]) - tos_pkg::norm_t'(y1_q[P]);
    assign ny_d[a] = tos_pkg::norm_t'(x1_q[P]) - tos_pkg::norm_t'(x1_q[Q]);
  end

  always_ff @(posedge clk_i) begin
    if (ld2) begin
      x2_q <= x1_q;
      y2_q <= y1_q;
      nx_q <= nx_d;
      ny_q <= ny_d;
    end
  end

  for (genvar a = 0; a < tos_pkg::NumAxis; a++) begin : g_axis
    tos_axis u_axis (
      .clk_i (clk_i),
      .ld_i  (stage_ld),
      .x_i   (x2_q),
      .y_i   (y2_q),
      .nx_i  (nx_q[a]),
      .ny_i  (ny_q[a]),
      .sep_o (sep[a])
    );
  end

  assign overlap_d = !(|sep);

  always_ff @(posedge clk_i) begin
    if (ld_out) overlap_q <= overlap_d;
  end

  assign out_o.valid   = ov_q;
  assign out_o.overlap = overlap_q;

  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> v1_q)
    else $error("accepted beat did not reach the input stage");

  a_ready_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (v1_q && v2_q && v3_q && v4_q && v5_q && ov_q))
    else $error("input stalled with an empty stage in the pipeline");

  a_last_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v5_q && ld_out) |=> out_o.valid)
    else $error("last stage beat lost on the way to the output");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !out_o.ready) |=> (ov_q && $stable(overlap_q)))
    else $error("output beat changed while the output was stalled");

endmodule

`default_nettype wire
